FILE: rtl/rhsv_pkg.sv
package rhsv_pkg;

  // Number of restoring division steps, one quotient bit per cell
  localparam int unsigned NUM_STEPS = 8;

  // Conversion constants
  localparam logic [7:0] HUE_SCALE  = 8'd43;
  localparam logic [7:0] BASE_RED   = 8'd0;
  localparam logic [7:0] BASE_GREEN = 8'd85;
  localparam logic [7:0] BASE_BLUE  = 8'd171;

  // Word carried down the division chain. Each lane holds a partial
  // remainder and a shift word that starts as the low numerator byte and
  // ends as the quotient.
  typedef struct packed {
    logic [7:0] rem_s;   // saturation lane: partial remainder
    logic [7:0] quo_s;   // saturation lane: numerator bits / quotient
    logic [7:0] div_s;   // saturation lane: divisor (max channel)
    logic [7:0] rem_h;   // hue lane: partial remainder
    logic [7:0] quo_h;   // hue lane: numerator bits / quotient
    logic [7:0] div_h;   // hue lane: divisor (spread)
    logic       neg;     // hue offset is subtracted from base
    logic [7:0] base;    // hue base of the dominant channel
    logic [7:0] value;   // max channel, passed through
  } rhsv_word_t;

  // One restoring step: returns {remainder, shifted quotient word}
  function automatic logic [15:0] div_step(input logic [7:0] rem,
                                           input logic [7:0] quo,
                                           input logic [7:0] dvs);
    logic [8:0] trial;
    logic [9:0] diff;
    logic       hit;
    logic [7:0] rem_nxt;
    trial   = {rem, quo[7]};
    diff    = {1'b0, trial} - {2'b00, dvs};
    hit     = ~diff[9];
    rem_nxt = hit ? diff[7:0] : trial[7:0];
    return {rem_nxt, quo[6:0], hit};
  endfunction

endpackage

FILE: rtl/rhsv_front.sv
module rhsv_front import rhsv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  output logic       up_ready,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output logic       dn_valid,
  input  logic       dn_ready,
  output rhsv_word_t dn_word
);

  logic       valid_r;
  rhsv_word_t word_r;
  rhsv_word_t word_nxt;

  logic [7:0]  hi;
  logic [7:0]  lo;
  logic [7:0]  spread;
  logic [15:0] num_s;
  logic [8:0]  diff;
  logic [7:0]  mag;
  logic [15:0] num_h;
  logic [7:0]  base;

  // Max, min and spread
  always_comb begin
    hi = red;
    if (green > hi) hi = green;
    if (blue > hi) hi = blue;
    lo = red;
    if (green < lo) lo = green;
    if (blue < lo) lo = blue;
    spread = hi - lo;
  end

  // Dominant channel, ties go red, then green, then blue
  always_comb begin
    if (red >= green && red >= blue) begin
      base = BASE_RED;
      diff = {1'b0, green} - {1'b0, blue};
    end else if (green >= blue) begin
      base = BASE_GREEN;
      diff = {1'b0, blue} - {1'b0, red};
    end else begin
      base = BASE_BLUE;
      diff = {1'b0, red} - {1'b0, green};
    end
    mag = diff[8] ? 8'(-diff) : diff[7:0];
  end

  // Numerators: spread*255 + max/2, and 43*|diff|
  assign num_s = {spread, 8'h00} - {8'h00, spread} + {9'h000, hi[7:1]};
  assign num_h = {8'h00, mag} * {8'h00, HUE_SCALE};

  always_comb begin
    word_nxt.rem_s = num_s[15:8];
    word_nxt.quo_s = num_s[7:0];
    word_nxt.div_s = hi;
    word_nxt.rem_h = num_h[15:8];
    word_nxt.quo_h = num_h[7:0];
    word_nxt.div_h = spread;
    word_nxt.neg   = diff[8];
    word_nxt.base  = base;
    word_nxt.value = hi;
  end

  // Stage register
  assign up_ready = ~valid_r | dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      word_r <= word_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_word  = word_r;

endmodule

FILE: rtl/rhsv_cell.sv
module rhsv_cell import rhsv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  output logic       up_ready,
  input  rhsv_word_t up_word,
  output logic       dn_valid,
  input  logic       dn_ready,
  output rhsv_word_t dn_word
);

  logic       valid_r;
  rhsv_word_t word_r;
  rhsv_word_t word_nxt;
  logic [15:0] step_s;
  logic [15:0] step_h;

  // One quotient bit for each lane
  assign step_s = div_step(up_word.rem_s, up_word.quo_s, up_word.div_s);
  assign step_h = div_step(up_word.rem_h, up_word.quo_h, up_word.div_h);

  always_comb begin
    word_nxt       = up_word;
    word_nxt.rem_s = step_s[15:8];
    word_nxt.quo_s = step_s[7:0];
    word_nxt.rem_h = step_h[15:8];
    word_nxt.quo_h = step_h[7:0];
  end

  // Stage register, advances when empty or when the next stage takes it
  assign up_ready = ~valid_r | dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      word_r <= word_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_word  = word_r;

endmodule

FILE: rtl/rgb_to_hsv_8bit_unit.sv
// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_ready    in_red, in_green, in_blue (8b each)
// out      output     out_valid/out_ready  out_hue, out_saturation, out_brightness
//
// One pixel per clock sustained while out_ready is high. Stages: a front stage, eight
// division cells (one quotient bit each, both divisions side by side) and
// the output register.
// Reset clears all stage valid bits; payload registers are not reset.
// Each stage holds when its successor is full and stalled, so bubbles close
// up and the input keeps accepting until the whole chain is full.
module rgb_to_hsv_8bit_unit import rhsv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_hue,
  output logic [7:0] out_saturation,
  output logic [7:0] out_brightness
);

  logic       ch_valid [NUM_STEPS+1];
  logic       ch_ready [NUM_STEPS+1];
  rhsv_word_t ch_word  [NUM_STEPS+1];

  logic       out_valid_r;
  logic [7:0] hue_r;
  logic [7:0] sat_r;
  logic [7:0] val_r;
  logic [7:0] hue_nxt;
  logic [7:0] sat_nxt;
  logic       tail_ready;
  rhsv_word_t tail;

  // Max/min, base and numerators
  rhsv_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .red      (in_red),
    .green    (in_green),
    .blue     (in_blue),
    .dn_valid (ch_valid[0]),
    .dn_ready (ch_ready[0]),
    .dn_word  (ch_word[0])
  );

  // Division chain
  for (genvar i = 0; i < NUM_STEPS; i++) begin : g_cell
    rhsv_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (ch_valid[i]),
      .up_ready (ch_ready[i]),
      .up_word  (ch_word[i]),
      .dn_valid (ch_valid[i+1]),
      .dn_ready (ch_ready[i+1]),
      .dn_word  (ch_word[i+1])
    );
  end

  assign tail = ch_word[NUM_STEPS];

  // Final fix-up: signed hue offset with wrap, black and gray pixels
  always_comb begin
    if (tail.div_h == 8'd0) begin
      hue_nxt = 8'd0;
    end else if (tail.neg) begin
      hue_nxt = tail.base - tail.quo_h;
    end else begin
      hue_nxt = tail.base + tail.quo_h;
    end
    sat_nxt = (tail.value == 8'd0) ? 8'd0 : tail.quo_s;
  end

  // Output register
  assign tail_ready           = ~out_valid_r | out_ready;
  assign ch_ready[NUM_STEPS]  = tail_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (tail_ready) begin
      out_valid_r <= ch_valid[NUM_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (tail_ready && ch_valid[NUM_STEPS]) begin
      hue_r <= hue_nxt;
      sat_r <= sat_nxt;
      val_r <= tail.value;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hue        = hue_r;
  assign out_saturation = sat_r;
  assign out_brightness = val_r;

  // Input stalls only when every stage is full and the output is held
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled with room in the chain");

  // Black pixel gives zero hue and saturation
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_brightness == 8'd0) |-> (out_hue == 8'd0 && out_saturation == 8'd0))
    else $error("black pixel with nonzero hue or saturation");

  // Zero saturation only for gray pixels, which have zero hue
  a_gray: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturation == 8'd0) |-> (out_hue == 8'd0))
    else $error("unsaturated pixel with nonzero hue");

  // Chain empties on reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

FILE: tb/sv/hsv_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the converter, predicts each result from the
// accepted request and compares it with what comes out, in order.
module hsv_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_hue,
  input  logic [7:0] out_saturation,
  input  logic [7:0] out_brightness,
  output int         fail_count,
  output int         pending_count,
  output int         pixels_done
);

  // Hue circle anchors and scale
  localparam int HUE_RED_BASE   = 0;
  localparam int HUE_GREEN_BASE = 85;
  localparam int HUE_BLUE_BASE  = 171;
  localparam int HUE_SPAN       = 43;
  localparam int FULL_SCALE     = 255;
  localparam int HUE_WRAP       = 256;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } hsv_pixel_t;

  // Converted pixels waiting for their result, oldest first
  hsv_pixel_t pending_hsv[$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
    pixels_done   = 0;
  end

  // Integer RGB to HSV on a 256-step hue circle
  function automatic hsv_pixel_t predict_hsv(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
    hsv_pixel_t px;
    int rv, gv, bv, hi, lo, spread, base, diff, h;
    rv = r;
    gv = g;
    bv = b;
    hi = rv;
    if (gv > hi) hi = gv;
    if (bv > hi) hi = bv;
    lo = rv;
    if (gv < lo) lo = gv;
    if (bv < lo) lo = bv;
    spread = hi - lo;

    px.red        = r;
    px.green      = g;
    px.blue       = b;
    px.brightness = 8'(hi);
    px.saturation = (hi == 0) ? 8'd0 : 8'((spread * FULL_SCALE + hi / 2) / hi);
    px.hue        = 8'd0;

    // Gray and black stay at hue 0; ties go red, then green, then blue
    if (spread != 0) begin
      if (hi == rv) begin
        base = HUE_RED_BASE;
        diff = gv - bv;
      end else if (hi == gv) begin
        base = HUE_GREEN_BASE;
        diff = bv - rv;
      end else begin
        base = HUE_BLUE_BASE;
        diff = rv - gv;
      end
      // signed division truncates toward zero
      h = base + (HUE_SPAN * diff) / spread;
      if (h < 0) h += HUE_WRAP;
      px.hue = 8'(h);
    end
    return px;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: MISMATCH %s", $time, msg);
    fail_count++;
  endtask

  // Compare results first, then queue the request accepted on this edge
  always @(posedge clk) begin
    hsv_pixel_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_hsv.size() == 0) begin
          report_mismatch($sformatf("result h=%0d s=%0d v=%0d with no pixel pending",
                                    out_hue, out_saturation, out_brightness));
        end else begin
          want = pending_hsv.pop_front();
          if ({out_hue, out_saturation, out_brightness} !=
              {want.hue, want.saturation, want.brightness}) begin
            report_mismatch($sformatf(
              "rgb=(%0d,%0d,%0d) got h=%0d s=%0d v=%0d, want h=%0d s=%0d v=%0d",
              want.red, want.green, want.blue, out_hue, out_saturation, out_brightness,
              want.hue, want.saturation, want.brightness));
          end
          pixels_done++;
        end
      end
      if (in_valid && in_ready) begin
        pending_hsv.push_back(predict_hsv(in_red, in_green, in_blue));
      end
    end
    pending_count = pending_hsv.size();
  end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT      = 200000;
  localparam int RANDOM_PER_PHASE = 430;
  localparam int DRAIN_CYCLES     = 20;

  // Shapes of random pixels
  typedef enum int {
    SHAPE_ANY,
    SHAPE_GRAY,
    SHAPE_TIE_RG,
    SHAPE_TIE_GB,
    SHAPE_TIE_RB,
    SHAPE_EXTREME,
    SHAPE_DIM,
    SHAPE_NEAR_GRAY
  } pixel_shape_e;

  logic       clk;
  logic       rst_n          = 1'b0;
  logic       in_valid       = 1'b0;
  logic       in_ready;
  logic [7:0] in_red         = 8'd0;
  logic [7:0] in_green       = 8'd0;
  logic [7:0] in_blue        = 8'd0;
  logic       out_valid;
  logic       out_ready      = 1'b0;
  logic [7:0] out_hue;
  logic [7:0] out_saturation;
  logic [7:0] out_brightness;

  int send_idle   = 36;
  int recv_idle   = 87;
  int cycle_count = 0;
  int fail_count;
  int pending_count;
  int pixels_done;

  rgb_to_hsv_8bit_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_brightness (out_brightness)
  );

  hsv_checker hsv_mon (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_brightness (out_brightness),
    .fail_count     (fail_count),
    .pending_count  (pending_count),
    .pixels_done    (pixels_done)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver stalls at random
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_idle);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", cycle_count, pending_count);
      $display("Verification failed");
      $finish;
    end
  end

  // One request; random gaps first, then hold until accepted
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      in_red   = 8'($urandom);
      in_green = 8'($urandom);
      in_blue  = 8'($urandom);
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_red   = r;
    in_green = g;
    in_blue  = b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_random_pixel();
    logic [7:0] r, g, b;
    int pick;
    pixel_shape_e shape;
    r = 8'($urandom);
    g = 8'($urandom);
    b = 8'($urandom);
    pick = $urandom_range(11);
    shape = (pick > SHAPE_NEAR_GRAY) ? SHAPE_ANY : pixel_shape_e'(pick);
    case (shape)
      SHAPE_GRAY: begin
        g = r;
        b = r;
      end
      SHAPE_TIE_RG: g = r;
      SHAPE_TIE_GB: b = g;
      SHAPE_TIE_RB: b = r;
      SHAPE_EXTREME: begin
        r = $urandom_range(1) ? 8'hff : 8'h00;
        g = $urandom_range(1) ? 8'hff : 8'h00;
        b = $urandom_range(1) ? 8'hff : ($urandom_range(1) ? 8'h01 : 8'hfe);
      end
      SHAPE_DIM: begin
        r = 8'($urandom_range(3));
        g = 8'($urandom_range(3));
        b = 8'($urandom_range(3));
      end
      SHAPE_NEAR_GRAY: begin
        g = r ^ 8'($urandom_range(3));
        b = r ^ 8'($urandom_range(3));
      end
      default: ;
    endcase
    send_pixel(r, g, b);
  endtask

  // Hold the sender until every result is back
  task automatic drain_results();
    in_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Corners: black, white, gray, primaries, ties, hue wrap, tiny spreads
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd1,   8'd1,   8'd1);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd255, 8'd0,   8'd128);
    send_pixel(8'd1,   8'd0,   8'd1);
    send_pixel(8'd255, 8'd0,   8'd1);
    send_pixel(8'd1,   8'd0,   8'd0);
    send_pixel(8'd0,   8'd1,   8'd0);
    send_pixel(8'd0,   8'd0,   8'd1);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd254, 8'd255, 8'd0);
    send_pixel(8'd128, 8'd0,   8'd255);
    send_pixel(8'd0,   8'd128, 8'd255);
    send_pixel(8'd2,   8'd1,   8'd0);
    send_pixel(8'd170, 8'd85,  8'd0);
    send_pixel(8'd85,  8'd170, 8'd255);

    // Sparse receiver, then sparse sender, then full rate
    for (int i = 0; i < RANDOM_PER_PHASE; i++) send_random_pixel();
    drain_results();
    send_idle = 87;
    recv_idle = 36;
    for (int i = 0; i < RANDOM_PER_PHASE; i++) send_random_pixel();
    drain_results();
    send_idle = 0;
    recv_idle = 0;
    for (int i = 0; i < RANDOM_PER_PHASE; i++) send_random_pixel();

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Checked %0d pixels: corner colors, gray and tied channels, random mixes",
             pixels_done);
    $display("Handshake profiles: slow receiver, slow sender, then back-to-back");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/rhsv_pkg.sv
rtl/rhsv_front.sv
rtl/rhsv_cell.sv
rtl/rgb_to_hsv_8bit_unit.sv
tb/sv/hsv_checker.sv
tb/sv/testbench.sv
